// ===== src/wbhs_pkg.sv =====
// Shared constants and codes for the write bandwidth hysteresis switch.
`default_nettype none
package wbhs_pkg;

    // Field widths
    localparam int BW_W   = 54;
    localparam int RUN_W  = 16;
    localparam int WORD_W = 32;
    localparam int FUNC_W = 2;
    localparam int CFG_W  = 64;
    localparam int ADDR_W = 5;

    // Item function codes carried on s_tuser
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENABLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET  = 2'd2;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_ENABLE_PER  = 2'd1;
    localparam logic [1:0] REG_DISABLE_PER = 2'd2;
    localparam logic [1:0] REG_EXPL_PER    = 2'd3;

    // Register reset values
    localparam logic [BW_W-1:0]  THRESHOLD_RST   = BW_W'(50 * 1024 * 1024);
    localparam logic [RUN_W-1:0] ENABLE_PER_RST  = RUN_W'(3);
    localparam logic [RUN_W-1:0] DISABLE_PER_RST = RUN_W'(5);
    localparam logic [RUN_W-1:0] EXPL_PER_RST    = RUN_W'(60);

    localparam logic [BW_W-1:0]  BW_MAX  = {BW_W{1'b1}};
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

endpackage
`default_nettype wire

// ===== src/write_bandwidth_hysteresis_switch_unit.sv =====
// Top level: bit-serial bandwidth computation and hysteresis switch decision.
//
// Usage:
//   Slave stream (s_tvalid/s_tready) takes one item per transaction:
//   s_tuser carries func (0 sample, 1 explicit enable, 2 reset to off),
//   s_tdata carries written_sectors and elapsed_ms. Master stream
//   (m_tvalid/m_tready) returns exactly one result per item.
//   A sample item runs a shift-and-add multiply by SECTOR_BYTES*1000, one
//   sectors bit per cycle, then a restoring divide by elapsed_ms, one
//   quotient bit per cycle for QW quotient bits (QW = max(55, 32 + bits
//   of SECTOR_BYTES*1000); 55 for the default), then the decision step.
//   Zero elapsed time and non-sample items skip the arithmetic and go
//   straight to the decision step. New items are taken only while idle;
//   once a result is loaded into the output register the unit returns to
//   idle, even while the receiver stalls; the decision step waits only
//   while that register is still full.
//   Reset clears the run counters, the explicit flag and the decision,
//   and loads the register reset values. Registers sit on the APB port
//   at byte addresses 0, 8, 16, 24; pready is always high.
`default_nettype none
module write_bandwidth_hysteresis_switch_unit #(
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] written_sectors, [63:32] elapsed_ms
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    // Master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [0] booster_on, [1] command_issued,
                                        // [2] explicit_mode, [56:3] bandwidth, rest 0
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int KMUL = SECTOR_BYTES * 1000;
    localparam int KW   = $clog2(KMUL + 1);
    localparam int PW   = 32 + KW;
    localparam int QW   = (PW > wbhs_pkg::BW_W) ? PW : wbhs_pkg::BW_W + 1;
    localparam int CW   = $clog2(QW);
    localparam int BW   = wbhs_pkg::BW_W;
    localparam int RW   = wbhs_pkg::RUN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DECIDE
    } state_t;

    // Control and output registers
    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    logic [RW-1:0]     over_reg, over_next;
    logic [RW-1:0]     under_reg, under_next;
    logic              expl_reg, expl_next;
    logic              dec_reg, dec_next;

    // Configuration registers
    logic [BW-1:0]     thr_reg;
    logic [RW-1:0]     en_per_reg;
    logic [RW-1:0]     dis_per_reg;
    logic [RW-1:0]     expl_per_reg;

    // Datapath registers
    logic [1:0]        func_reg, func_next;
    logic              zero_ms_reg, zero_ms_next;
    logic [31:0]       sect_reg, sect_next;
    logic [31:0]       ms_reg, ms_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [31:0]       rem_reg, rem_next;

    logic              cfg_wr;
    logic              out_free;
    logic              in_acc;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= wbhs_pkg::THRESHOLD_RST;
            en_per_reg   <= wbhs_pkg::ENABLE_PER_RST;
            dis_per_reg  <= wbhs_pkg::DISABLE_PER_RST;
            expl_per_reg <= wbhs_pkg::EXPL_PER_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                wbhs_pkg::REG_THRESHOLD:   thr_reg      <= pwdata[BW-1:0];
                wbhs_pkg::REG_ENABLE_PER:  en_per_reg   <= pwdata[RW-1:0];
                wbhs_pkg::REG_DISABLE_PER: dis_per_reg  <= pwdata[RW-1:0];
                wbhs_pkg::REG_EXPL_PER:    expl_per_reg <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[4:3])
            wbhs_pkg::REG_THRESHOLD:   prdata = {{(64-BW){1'b0}}, thr_reg};
            wbhs_pkg::REG_ENABLE_PER:  prdata = {{(64-RW){1'b0}}, en_per_reg};
            wbhs_pkg::REG_DISABLE_PER: prdata = {{(64-RW){1'b0}}, dis_per_reg};
            wbhs_pkg::REG_EXPL_PER:    prdata = {{(64-RW){1'b0}}, expl_per_reg};
            default:                   prdata = '0;
        endcase
    end

    // Next-state logic: sequencer, multiply/divide steps, decision
    always_comb
    begin
        logic [32:0]    trial;
        logic           fits;
        logic [BW-1:0]  bw;
        logic           ge_thr;
        logic           target;
        logic           cmd;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        over_next     = over_reg;
        under_next    = under_reg;
        expl_next     = expl_reg;
        dec_next      = dec_reg;
        func_next     = func_reg;
        zero_ms_next  = zero_ms_reg;
        sect_next     = sect_reg;
        ms_next       = ms_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;

        trial  = {rem_reg, q_reg[QW-1]};
        fits   = (trial >= {1'b0, ms_reg});
        target = dec_reg;
        cmd    = 1'b0;

        // Quotient clamp to the bandwidth width
        if (zero_ms_reg || (|q_reg[QW-1:BW]))
            bw = wbhs_pkg::BW_MAX;
        else
            bw = q_reg[BW-1:0];
        ge_thr = (bw >= thr_reg);

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    func_next    = s_tuser;
                    sect_next    = s_tdata[31:0];
                    ms_next      = s_tdata[63:32];
                    zero_ms_next = (s_tdata[63:32] == 32'd0);
                    q_next       = '0;
                    rem_next     = '0;
                    cnt_next     = CW'(31);
                    if (s_tuser == wbhs_pkg::FUNC_SAMPLE && s_tdata[63:32] != 32'd0)
                        state_next = ST_MUL;
                    else
                        state_next = ST_DECIDE;
                end
            end

            ST_MUL:
            begin
                // Shift-and-add, sectors MSB first
                q_next    = {q_reg[QW-2:0], 1'b0} + (sect_reg[31] ? QW'(KMUL) : '0);
                sect_next = {sect_reg[30:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CW'(QW - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // Restoring divide, one quotient bit per cycle
                rem_next = fits ? 32'(trial - {1'b0, ms_reg}) : trial[31:0];
                q_next   = {q_reg[QW-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (out_free)
                begin
                    case (func_reg)
                        wbhs_pkg::FUNC_SAMPLE:
                        begin
                            if (ge_thr)
                            begin
                                over_next  = (over_reg == wbhs_pkg::RUN_MAX) ?
                                             over_reg : over_reg + 1'b1;
                                under_next = '0;
                            end
                            else
                            begin
                                over_next  = '0;
                                under_next = (under_reg == wbhs_pkg::RUN_MAX) ?
                                             under_reg : under_reg + 1'b1;
                            end
                            if (over_next >= en_per_reg)
                                target = 1'b1;
                            if (!expl_reg && under_next >= dis_per_reg)
                                target = 1'b0;
                            if (expl_reg && under_next >= expl_per_reg)
                                target = 1'b0;
                            if (target != dec_reg)
                            begin
                                cmd      = 1'b1;
                                dec_next = target;
                                if (!target)
                                    expl_next = 1'b0;
                            end
                        end
                        wbhs_pkg::FUNC_ENABLE:
                        begin
                            expl_next  = 1'b1;
                            over_next  = '0;
                            under_next = '0;
                            dec_next   = 1'b1;
                            cmd        = 1'b1;
                        end
                        wbhs_pkg::FUNC_RESET:
                        begin
                            expl_next  = 1'b0;
                            over_next  = '0;
                            under_next = '0;
                            dec_next   = 1'b0;
                            cmd        = 1'b1;
                        end
                        default: ;
                    endcase
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(64-BW-3){1'b0}},
                                     (func_reg == wbhs_pkg::FUNC_SAMPLE) ? bw : {BW{1'b0}},
                                     expl_next, cmd, dec_next};
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            over_reg     <= '0;
            under_reg    <= '0;
            expl_reg     <= 1'b0;
            dec_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            over_reg     <= over_next;
            under_reg    <= under_next;
            expl_reg     <= expl_next;
            dec_reg      <= dec_next;
        end
    end

    // Arithmetic datapath
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        zero_ms_reg <= zero_ms_next;
        sect_reg    <= sect_next;
        ms_reg      <= ms_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
    end

    // Checks
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(over_reg != '0 && under_reg != '0))
        else $error("over and under run counters both nonzero");

    a_explicit_implies_on: assert property (@(posedge clk) disable iff (!rst_n)
        expl_reg |-> dec_reg)
        else $error("explicit mode set while switch is off");

    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[2] && !m_tdata_reg[0]))
        else $error("result shows explicit mode with booster off");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && out_free) |=> (state_reg == ST_IDLE && m_tvalid_reg))
        else $error("decision cycle did not produce a result");

endmodule
`default_nettype wire
